[hdl/tile_spotlight_shader_macros.svh]
// Assertion macros used by the tile spotlight shader top module.
`ifndef TILE_SPOTLIGHT_SHADER_MACROS_SVH
`define TILE_SPOTLIGHT_SHADER_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define TSS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tss assertion failed");
// Check that a condition never occurs outside reset.
`define TSS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tss forbidden condition seen");
`else
`define TSS_ASSERT(lbl, clk, rst, prop)
`define TSS_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

[hdl/tss_pkg.sv]
package tss_pkg;

   // Default screen geometry
   localparam int SCREEN_W_DEF = 80;
   localparam int SCREEN_H_DEF = 64;

   // Field and datapath widths
   localparam int PX_W       = 7;
   localparam int PY_W       = 6;
   localparam int COLOR_W    = 16;
   localparam int CODE_W     = 3;
   localparam int SQ_W       = 15;
   localparam int R2_W       = 16;
   localparam int SHIFT_W    = 4;
   localparam int LUX_W      = 5;
   localparam int PAL_AW     = 8;
   localparam int TILE_AW    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register indexes on the CSR channel
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALO_SHIFT = 2'd2;

   // Register reset values
   localparam logic [SHIFT_W-1:0] HALO_SHIFT_RST = 4'd10;

   typedef struct packed {
      logic [7:0]         offset_x;
      logic [7:0]         offset_y;
      logic [SHIFT_W-1:0] halo_shift;
   } csr_type;

   // Stage 1 output: tile code read plus the two squared offsets
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [SQ_W-1:0]   dx2;
      logic [SQ_W-1:0]   dy2;
   } fetch_type;

   // Final shaded pixel
   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
      logic               lit;
   } result_type;

endpackage

[hdl/tile_spotlight_shader.sv]
// Tile spotlight shader: one screen pixel in, one 16-bit color out.
// Request channel: drive req_px and req_py with start high; the pixel is
// taken at every rising edge where start is high and busy is low. busy is
// high only while reset is applied and in the cycle after it, so a new
// pixel may be offered on every clock cycle.
// Response channel: rsp_strobe is high for exactly one cycle, with rsp_color
// and rsp_lit valid in that cycle. Each pixel passes through a three-stage
// pipeline (tile memory read and squaring, distance sum, palette read)
// before its result is on the response ports. Results come out in request
// order, one per request, at one per cycle.
// The receiver cannot stall the response channel; results are not held.
// CSR channel: csr_ready is always high; a write of csr_wdata to register
// csr_index happens when csr_valid is high. Index 0 is offset_x, 1 is
// offset_y, 2 is halo_shift; other indexes are ignored. Write only while no
// pixel is in flight.
// Reset (synchronous, active high) empties the pipeline and sets the scroll
// offsets to 0 and halo_shift to 10.
`include "tile_spotlight_shader_macros.svh"
module tile_spotlight_shader #(
   parameter int SCREEN_W = tss_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = tss_pkg::SCREEN_H_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tss_pkg::PX_W-1:0]         req_px,
   input  logic [tss_pkg::PY_W-1:0]         req_py,
   output logic                             rsp_strobe,
   output logic [tss_pkg::COLOR_W-1:0]      rsp_color,
   output logic                             rsp_lit,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tss_pkg::*;

   csr_type    csr_in, csr_ff;
   logic       busy_in, busy_ff;
   logic       take;
   fetch_type  fetch;
   result_type result;

   // Decode CSR writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET_X:   csr_in.offset_x   = csr_wdata;
            CSR_OFFSET_Y:   csr_in.offset_y   = csr_wdata;
            CSR_HALO_SHIFT: csr_in.halo_shift = csr_wdata[SHIFT_W-1:0];
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{offset_x: 8'd0, offset_y: 8'd0, halo_shift: HALO_SHIFT_RST};
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Hold off requests through reset and the cycle after it
   assign busy_in = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign take      = start && !busy_ff;

   tss_fetch #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_fetch (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .px    (req_px),
      .py    (req_py),
      .csr   (csr_ff),
      .fetch (fetch)
   );

   tss_shade u_shade (
      .clock      (clock),
      .reset      (reset),
      .fetch      (fetch),
      .halo_shift (csr_ff.halo_shift),
      .result     (result)
   );

   assign rsp_strobe = result.valid;
   assign rsp_color  = result.color;
   assign rsp_lit    = result.lit;

   `TSS_ASSERT(a_rsp_has_req, clock, reset, rsp_strobe |-> $past(start && !busy, 3))
   `TSS_ASSERT(a_req_gets_rsp, clock, reset, start && !busy |=> ##2 rsp_strobe)
   `TSS_ASSERT(a_unlit_is_black, clock, reset, rsp_strobe && !rsp_lit |-> rsp_color == '0)
   `TSS_ASSERT_NEVER(a_no_rsp_while_busy, clock, reset, busy && rsp_strobe)

endmodule

[hdl/tss_fetch.sv]
module tss_fetch #(
   parameter int SCREEN_W = tss_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = tss_pkg::SCREEN_H_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [tss_pkg::PX_W-1:0]  px,
   input  logic [tss_pkg::PY_W-1:0]  py,
   input  tss_pkg::csr_type          csr,
   output tss_pkg::fetch_type        fetch
);
   import tss_pkg::*;

   localparam logic [8:0] CX = 9'(SCREEN_W / 2);
   localparam logic [8:0] CY = 9'(SCREEN_H / 2);
   localparam logic [3:0] TILE_LAST = 4'd15;

   // Tile bitmap contents: beveled border, light or dark fill
   function automatic logic [CODE_W-1:0] texel_code(input logic [TILE_AW-1:0] a);
      logic              dark;
      logic [3:0]        row;
      logic [3:0]        col;
      logic              top_e;
      logic              bot_e;
      logic              lft_e;
      logic              rgt_e;
      logic [CODE_W-1:0] code;
      dark  = a[8];
      row   = a[7:4];
      col   = a[3:0];
      top_e = (row == 4'd0);
      bot_e = (row == TILE_LAST);
      lft_e = (col == 4'd0);
      rgt_e = (col == TILE_LAST);
      priority if ((top_e || bot_e) && (lft_e || rgt_e)) code = 3'd0;
      else if (top_e) code = 3'd1;
      else if (bot_e) code = 3'd3;
      else if (lft_e) code = 3'd1;
      else if (rgt_e) code = 3'd3;
      else code = dark ? 3'd4 : 3'd2;
      return code;
   endfunction

   logic [7:0]          xo;
   logic [7:0]          yo;
   logic [TILE_AW-1:0]  tile_addr;
   logic signed [8:0]   dx;
   logic signed [8:0]   dy;
   logic signed [17:0]  dx_sq;
   logic signed [17:0]  dy_sq;

   logic                valid_in,  valid_ff;
   logic [CODE_W-1:0]   code_in,   code_ff;
   logic [SQ_W-1:0]     dx2_in,    dx2_ff;
   logic [SQ_W-1:0]     dy2_in,    dy2_ff;

   // Scroll the coordinates and form the tile memory address
   always_comb begin
      xo        = {1'b0, px} + csr.offset_x;
      yo        = {2'b00, py} + csr.offset_y;
      tile_addr = {xo[4] ^ yo[4], yo[3:0], xo[3:0]};
   end

   // Signed offsets from the screen center and their squares
   always_comb begin
      dx     = $signed({2'b00, px}) - $signed(CX);
      dy     = $signed({3'b000, py}) - $signed(CY);
      dx_sq  = dx * dx;
      dy_sq  = dy * dy;
      dx2_in = dx_sq[SQ_W-1:0];
      dy2_in = dy_sq[SQ_W-1:0];
   end

   assign valid_in = take;
   assign code_in  = texel_code(tile_addr);

   // Advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Synchronous tile memory read and registered squares
   always_ff @(posedge clock) begin
      code_ff <= code_in;
      dx2_ff  <= dx2_in;
      dy2_ff  <= dy2_in;
   end

   assign fetch = '{valid: valid_ff, code: code_ff, dx2: dx2_ff, dy2: dy2_ff};

endmodule

[hdl/tss_shade.sv]
module tss_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  tss_pkg::fetch_type            fetch,
   input  logic [tss_pkg::SHIFT_W-1:0]   halo_shift,
   output tss_pkg::result_type           result
);
   import tss_pkg::*;

   localparam int PAL_DEPTH = 129;
   localparam logic [8:0] PAL_LAST = 9'd128;

   // Shaded palette, 32 brightness levels per bitmap code
   localparam logic [COLOR_W-1:0] PALETTE [PAL_DEPTH] = '{
      16'hffff,
      16'h79ce, 16'h38c6, 16'hf7bd, 16'hd7bd, 16'h96b5, 16'h75ad, 16'h34a5, 16'hf39c,
      16'hd39c, 16'h9294, 16'h718c, 16'h3084, 16'h1084, 16'hcf7b, 16'h8e73, 16'h6d6b,
      16'h2c63, 16'h0c63, 16'hcb5a, 16'h8a52, 16'h694a, 16'h2842, 16'h0842, 16'hc739,
      16'h8631, 16'h6529, 16'h2421, 16'h0421, 16'hc318, 16'h8210, 16'h6108, 16'h2000,
      16'h55ad, 16'h34a5, 16'hf39c, 16'hd39c, 16'hb294, 16'h718c, 16'h518c, 16'h3084,
      16'h1084, 16'hcf7b, 16'hae73, 16'h8e73, 16'h4d6b, 16'h2c63, 16'h0c63, 16'hcb5a,
      16'haa52, 16'h8a52, 16'h494a, 16'h2842, 16'h0842, 16'hc739, 16'ha631, 16'h8631,
      16'h4529, 16'h2421, 16'h0421, 16'hc318, 16'ha210, 16'h8210, 16'h4108, 16'h2000,
      16'h2842, 16'h0842, 16'h0842, 16'he739, 16'he739, 16'hc739, 16'ha631, 16'ha631,
      16'h8631, 16'h8631, 16'h6529, 16'h6529, 16'h4529, 16'h4529, 16'h2421, 16'h2421,
      16'h0421, 16'h0421, 16'he318, 16'he318, 16'hc318, 16'ha210, 16'ha210, 16'h8210,
      16'h8210, 16'h6108, 16'h6108, 16'h4108, 16'h4108, 16'h2000, 16'h2000, 16'h0000,
      16'h518c, 16'h3084, 16'h1084, 16'hcf7b, 16'hae73, 16'h8e73, 16'h6d6b, 16'h4d6b,
      16'h2c63, 16'h0c63, 16'heb5a, 16'hcb5a, 16'haa52, 16'h8a52, 16'h694a, 16'h494a,
      16'h2842, 16'h0842, 16'he739, 16'ha631, 16'h8631, 16'h6529, 16'h4529, 16'h2421,
      16'h0421, 16'he318, 16'hc318, 16'ha210, 16'h8210, 16'h6108, 16'h4108, 16'h2000
   };

   // Stage 2: squared distance
   logic               v2_in,    v2_ff;
   logic [CODE_W-1:0]  code2_in, code2_ff;
   logic [R2_W-1:0]    r2_in,    r2_ff;

   // Stage 3: palette read
   logic               v3_in,    v3_ff;
   logic [COLOR_W-1:0] color_in, color_ff;
   logic               lit_in,   lit_ff;

   logic [R2_W-1:0]         r2_scaled;
   logic [R2_W+LUX_W-1:0]   lux_wide;
   logic [LUX_W-1:0]        lux;
   logic [CODE_W-1:0]       code_m1;
   logic [8:0]              pal_sum;
   logic [PAL_AW-1:0]       pal_idx;
   logic                    hit;

   // Sum the squares
   always_comb begin
      v2_in    = fetch.valid;
      code2_in = fetch.code;
      r2_in    = R2_W'(fetch.dx2) + R2_W'(fetch.dy2);
   end

   // Halo test, brightness level and palette address
   always_comb begin
      r2_scaled = r2_ff >> halo_shift;
      lux_wide  = {r2_ff, {LUX_W{1'b0}}} >> halo_shift;
      lux       = lux_wide[LUX_W-1:0];
      code_m1   = code2_ff - 3'd1;
      pal_sum   = 9'd1 + {1'b0, code_m1, {LUX_W{1'b0}}} + {4'd0, lux};
      pal_idx   = (pal_sum > PAL_LAST) ? PAL_LAST[PAL_AW-1:0] : pal_sum[PAL_AW-1:0];
      hit       = (r2_scaled == '0) && (code2_ff != '0);
      v3_in     = v2_ff;
      lit_in    = hit;
   end

   // Palette memory read, dark when outside the halo or transparent
   always_ff @(posedge clock) begin
      color_ff <= hit ? PALETTE[pal_idx] : '0;
   end

   assign color_in = color_ff;

   // Advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Hold the payload of each stage
   always_ff @(posedge clock) begin
      code2_ff <= code2_in;
      r2_ff    <= r2_in;
      lit_ff   <= lit_in;
   end

   assign result = '{valid: v3_ff, color: color_in, lit: lit_ff};

endmodule

[sim/tile_spotlight_shader_tb.sv]
module tile_spotlight_shader_tb;
   import tss_pkg::*;

   // Bitmap codes of the tile texels
   localparam logic [CODE_W-1:0] CODE_CLEAR      = 3'd0;
   localparam logic [CODE_W-1:0] CODE_HIGHLIGHT  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_LIGHT_FILL = 3'd2;
   localparam logic [CODE_W-1:0] CODE_SHADOW     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_DARK_FILL  = 3'd4;

   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int CENTER_X        = SCREEN_W_DEF / 2;
   localparam int CENTER_Y        = SCREEN_H_DEF / 2;
   localparam int TILE_LAST       = 15;
   localparam int PALETTE_LAST    = 128;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int PHASES          = 10;
   localparam int PIXELS_PER_PHASE = 155;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               lit;
   } shade_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic                  busy;
   logic [PX_W-1:0]       req_px     = '0;
   logic [PY_W-1:0]       req_py     = '0;
   logic                  rsp_strobe;
   logic [COLOR_W-1:0]    rsp_color;
   logic                  rsp_lit;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Mirror of the block's registers
   logic [7:0]            cfg_offset_x   = 8'd0;
   logic [7:0]            cfg_offset_y   = 8'd0;
   logic [SHIFT_W-1:0]    cfg_halo_shift = HALO_SHIFT_RST;

   shade_type             expected_pixels[$];
   int                    errors          = 0;
   int                    pixels_sent     = 0;
   int                    results_checked = 0;
   int                    lit_seen        = 0;
   int                    reg_writes      = 0;
   int                    idle_cycles     = 0;
   int                    idle_pct        = 0;

   logic [COLOR_W-1:0] shade_palette [0:128] = '{
      16'hffff,
      16'h79ce, 16'h38c6, 16'hf7bd, 16'hd7bd, 16'h96b5, 16'h75ad, 16'h34a5, 16'hf39c,
      16'hd39c, 16'h9294, 16'h718c, 16'h3084, 16'h1084, 16'hcf7b, 16'h8e73, 16'h6d6b,
      16'h2c63, 16'h0c63, 16'hcb5a, 16'h8a52, 16'h694a, 16'h2842, 16'h0842, 16'hc739,
      16'h8631, 16'h6529, 16'h2421, 16'h0421, 16'hc318, 16'h8210, 16'h6108, 16'h2000,
      16'h55ad, 16'h34a5, 16'hf39c, 16'hd39c, 16'hb294, 16'h718c, 16'h518c, 16'h3084,
      16'h1084, 16'hcf7b, 16'hae73, 16'h8e73, 16'h4d6b, 16'h2c63, 16'h0c63, 16'hcb5a,
      16'haa52, 16'h8a52, 16'h494a, 16'h2842, 16'h0842, 16'hc739, 16'ha631, 16'h8631,
      16'h4529, 16'h2421, 16'h0421, 16'hc318, 16'ha210, 16'h8210, 16'h4108, 16'h2000,
      16'h2842, 16'h0842, 16'h0842, 16'he739, 16'he739, 16'hc739, 16'ha631, 16'ha631,
      16'h8631, 16'h8631, 16'h6529, 16'h6529, 16'h4529, 16'h4529, 16'h2421, 16'h2421,
      16'h0421, 16'h0421, 16'he318, 16'he318, 16'hc318, 16'ha210, 16'ha210, 16'h8210,
      16'h8210, 16'h6108, 16'h6108, 16'h4108, 16'h4108, 16'h2000, 16'h2000, 16'h0000,
      16'h518c, 16'h3084, 16'h1084, 16'hcf7b, 16'hae73, 16'h8e73, 16'h6d6b, 16'h4d6b,
      16'h2c63, 16'h0c63, 16'heb5a, 16'hcb5a, 16'haa52, 16'h8a52, 16'h694a, 16'h494a,
      16'h2842, 16'h0842, 16'he739, 16'ha631, 16'h8631, 16'h6529, 16'h4529, 16'h2421,
      16'h0421, 16'he318, 16'hc318, 16'ha210, 16'h8210, 16'h6108, 16'h4108, 16'h2000
   };

   tile_spotlight_shader dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_px     (req_px),
      .req_py     (req_py),
      .rsp_strobe (rsp_strobe),
      .rsp_color  (rsp_color),
      .rsp_lit    (rsp_lit),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Texel code: corners clear, top and left edges bright, bottom and right shaded
   function automatic logic [CODE_W-1:0] texel_code(input logic dark,
                                                    input logic [3:0] row,
                                                    input logic [3:0] col);
      logic edge_row, edge_col;
      edge_row = (row == 4'd0) || (row == 4'(TILE_LAST));
      edge_col = (col == 4'd0) || (col == 4'(TILE_LAST));
      if (edge_row && edge_col) return CODE_CLEAR;
      if (row == 4'd0) return CODE_HIGHLIGHT;
      if (row == 4'(TILE_LAST)) return CODE_SHADOW;
      if (col == 4'd0) return CODE_HIGHLIGHT;
      if (col == 4'(TILE_LAST)) return CODE_SHADOW;
      return dark ? CODE_DARK_FILL : CODE_LIGHT_FILL;
   endfunction

   // Color of one pixel under the current scroll and halo settings
   function automatic shade_type shade_pixel(input logic [PX_W-1:0] x,
                                             input logic [PY_W-1:0] y);
      logic [7:0]        xo, yo;
      logic [CODE_W-1:0] code;
      int                dx, dy;
      int unsigned       r2, lux, pal_index;
      shade_type         pixel;
      xo = 8'(x + cfg_offset_x);
      yo = 8'(y + cfg_offset_y);
      code = texel_code(xo[4] ^ yo[4], yo[3:0], xo[3:0]);
      dx = int'(x) - CENTER_X;
      dy = int'(y) - CENTER_Y;
      r2 = dx * dx + dy * dy;
      pixel = '0;
      if ((r2 >> cfg_halo_shift) == 0 && code != CODE_CLEAR) begin
         lux = ((r2 << LUX_W) >> cfg_halo_shift) & 31;
         pal_index = 1 + (int'(code) - 1) * 32 + lux;
         if (pal_index > PALETTE_LAST) pal_index = PALETTE_LAST;
         pixel.color = shade_palette[pal_index];
         pixel.lit = 1'b1;
      end
      return pixel;
   endfunction

   // Check each result, track register writes, predict each accepted pixel
   always @(posedge clock) begin : track_transactions
      shade_type want;
      if (reset) begin
         cfg_offset_x = 8'd0;
         cfg_offset_y = 8'd0;
         cfg_halo_shift = HALO_SHIFT_RST;
      end else begin
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no pixel pending: color %h lit %b", rsp_color, rsp_lit);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               results_checked++;
               if (want.lit) lit_seen++;
               if (rsp_color !== want.color) begin
                  $error("color mismatch: expected %h, actual %h", want.color, rsp_color);
                  errors++;
               end
               if (rsp_lit !== want.lit) begin
                  $error("lit mismatch: expected %b, actual %b", want.lit, rsp_lit);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            reg_writes++;
            case (csr_index)
               CSR_OFFSET_X: cfg_offset_x = csr_wdata;
               CSR_OFFSET_Y: cfg_offset_y = csr_wdata;
               CSR_HALO_SHIFT: cfg_halo_shift = csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_pixels.push_back(shade_pixel(req_px, req_py));
            pixels_sent++;
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one pixel, hold it until taken, then maybe idle
   task automatic send_pixel(input logic [PX_W-1:0] x, input logic [PY_W-1:0] y);
      req_px <= x;
      req_py <= y;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   // Drop start and wait until every pixel in flight has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Write all three registers back to back once the pipeline is empty
   task automatic set_config(input logic [7:0] ox, input logic [7:0] oy,
                             input logic [CSR_DATA_W-1:0] halo_raw);
      wait_drained();
      write_register(CSR_OFFSET_X, ox);
      write_register(CSR_OFFSET_Y, oy);
      write_register(CSR_HALO_SHIFT, halo_raw);
      csr_valid <= 1'b0;
   endtask

   // Reset values: centre, corners, tile edges, beyond the screen
   task automatic test_default_setting();
      send_pixel(7'(CENTER_X), 6'(CENTER_Y));
      send_pixel(7'd0, 6'd0);
      send_pixel(7'd79, 6'd63);
      send_pixel(7'd47, 6'd47);
      send_pixel(7'd48, 6'd40);
      send_pixel(7'd127, 6'd63);
      send_pixel(7'd100, 6'd20);
   endtask

   // Halo zero lights only the centre, and not when its texel is clear
   task automatic test_halo_zero();
      set_config(8'd0, 8'd0, 8'hf0);
      send_pixel(7'(CENTER_X), 6'(CENTER_Y));
      send_pixel(7'(CENTER_X + 1), 6'(CENTER_Y));
      set_config(8'd8, 8'd0, 8'h00);
      send_pixel(7'(CENTER_X), 6'(CENTER_Y));
   endtask

   // Dimmest level of the shadow code maps to black yet counts as lit
   task automatic test_lit_black();
      set_config(8'd0, 8'd10, 8'd7);
      send_pixel(7'(CENTER_X + 10), 6'(CENTER_Y + 5));
      send_pixel(7'(CENTER_X + 11), 6'(CENTER_Y + 2));
   endtask

   // Halo shifts above the nominal range light the whole field
   task automatic test_large_halo();
      set_config(8'd3, 8'd5, 8'hff);
      send_pixel(7'd0, 6'd0);
      send_pixel(7'd127, 6'd0);
      send_pixel(7'd127, 6'd63);
      set_config(8'd3, 8'd5, 8'h0d);
      send_pixel(7'd0, 6'd63);
      send_pixel(7'd90, 6'd33);
   endtask

   // Largest offsets wrap the shifted coordinates
   task automatic test_scroll_wrap();
      set_config(8'hff, 8'hff, 8'h0c);
      send_pixel(7'd0, 6'd0);
      send_pixel(7'd1, 6'd1);
      send_pixel(7'd127, 6'd63);
      send_pixel(7'(CENTER_X), 6'(CENTER_Y));
   endtask

   // A write to the unused index must leave every register alone
   task automatic test_unused_register();
      set_config(8'd21, 8'd37, 8'h09);
      @(negedge clock);
      write_register(CSR_UNUSED, 8'ha5);
      csr_valid <= 1'b0;
      send_pixel(7'(CENTER_X + 3), 6'(CENTER_Y - 4));
      send_pixel(7'(CENTER_X - 9), 6'(CENTER_Y + 7));
   endtask

   // Random pixels over several settings; no idling in the last phases
   task automatic test_random_pixels();
      logic [7:0]            ox, oy;
      logic [CSR_DATA_W-1:0] halo_raw;
      int                    mode;
      int                    x, y;
      for (int phase = 0; phase < PHASES; phase++) begin
         ox = 8'($urandom_range(0, 255));
         oy = 8'($urandom_range(0, 255));
         halo_raw = 8'($urandom_range(0, 255));
         case (phase)
            0: begin ox = 8'd0; oy = 8'd0; halo_raw[3:0] = 4'd0; end
            1: begin ox = 8'hff; oy = 8'hff; halo_raw[3:0] = 4'd15; end
            2: begin ox = 8'd0; oy = 8'hff; halo_raw[3:0] = 4'd12; end
            default: ;
         endcase
         set_config(ox, oy, halo_raw);
         if (phase >= PHASES - 2) idle_pct = 0;
         else idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 15 : 40);
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
               x = CENTER_X + $urandom_range(0, 4) - 2;
               y = CENTER_Y + $urandom_range(0, 4) - 2;
            end else if (mode < 5) begin
               x = CENTER_X + $urandom_range(0, 32) - 16;
               y = CENTER_Y + $urandom_range(0, 32) - 16;
            end else if (mode < 8) begin
               x = $urandom_range(0, SCREEN_W_DEF - 1);
               y = $urandom_range(0, SCREEN_H_DEF - 1);
            end else begin
               x = $urandom_range(0, 127);
               y = $urandom_range(0, 63);
            end
            send_pixel(7'(x), 6'(y));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_pct = 25;
      test_default_setting();
      test_halo_zero();
      test_lit_black();
      test_large_halo();
      test_scroll_wrap();
      test_unused_register();
      test_random_pixels();
      wait_drained();
      // Let any stray result show up before the verdict
      repeat (8) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected results never arrived", expected_pixels.size());
         errors++;
      end
      $display("shaded %0d pixels, checked %0d results (%0d lit), %0d register writes",
               pixels_sent, results_checked, lit_seen, reg_writes);
      $display("covered zero, nominal and oversized halo shifts, offset wrap, clear texels");
      $display("and off-screen pixels");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[tile_spotlight_shader.f]
+incdir+hdl
hdl/tss_pkg.sv
hdl/tss_fetch.sv
hdl/tss_shade.sv
hdl/tile_spotlight_shader.sv
sim/tile_spotlight_shader_tb.sv
